// File: rtl/bffa_pkg.sv
// Shared types and constants for the bitmap first-fit block allocator.
// No dependencies; every other file imports this package.
package bffa_pkg;

    localparam int NUM_BLOCKS  = 1024;
    localparam int BLOCK_BYTES = 64;
    localparam int BLK_W       = $clog2(NUM_BLOCKS);
    localparam int CNT_W       = BLK_W + 1;
    localparam int OFF_W       = $clog2(BLOCK_BYTES);
    localparam int WORD_W      = 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int WORDS       = NUM_BLOCKS / WORD_W;
    localparam int WADDR_W     = $clog2(WORDS);
    localparam int CHUNK       = 8;
    localparam int CHUNK_W     = $clog2(CHUNK);
    localparam int CFG_IDX_W   = 2;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BLOCKS = 2'd1;

    typedef enum logic [2:0] {
        ST_OK, ST_ZERO, ST_EXHAUSTED, ST_NULL,
        ST_RANGE, ST_MISALIGNED, ST_NOT_ALLOC, ST_UNINIT
    } t_status;

    typedef enum logic [1:0] {
        KIND_ZERO, KIND_IDX, KIND_RUN
    } t_res_kind;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_RL_CHK, S_SCAN_RD, S_SCAN,
        S_MOD_RD, S_MOD_WR, S_DONE
    } t_state;

    typedef struct packed {
        logic      clr_start;
        logic      clr_step;
        logic      load_in;
        logic      scan_init;
        logic      scan_rd;
        logic      scan_step;
        logic      rl_rd;
        logic      take_run;
        logic      mod_rd;
        logic      mod_wr;
        logic      set_res;
        t_status   res_status;
        t_res_kind res_kind;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic    cfg_wr;
        logic    clr_last;
        logic    uninit;
        logic    is_alloc;
        logic    is_free;
        logic    req_zero;
        logic    req_exh;
        t_status loc_status;
        logic    rl_zero;
        logic    scan_found;
        logic    scan_end;
        logic    scan_wrap;
        logic    mod_last;
        logic    out_free;
    } t_dp_stat;

endpackage

// File: rtl/bffa_ctrl.sv
// Controller state machine of the allocator: sequences clear, check, scan and update.
// Depends on bffa_pkg; drives the datapath through t_dp_cmd.
module bffa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bffa_pkg::t_dp_stat i_stat,
    output bffa_pkg::t_dp_cmd  o_cmd
);
    import bffa_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = !i_stat.cfg_wr;
                if (i_in_valid && !i_stat.cfg_wr) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.uninit) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_UNINIT;
                    o_cmd.res_kind   = KIND_ZERO;
                    n_state = S_DONE;
                end else if (i_stat.is_alloc && i_stat.req_zero) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_ZERO;
                    o_cmd.res_kind   = KIND_ZERO;
                    n_state = S_DONE;
                end else if (i_stat.is_alloc && i_stat.req_exh) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_EXHAUSTED;
                    o_cmd.res_kind   = KIND_ZERO;
                    n_state = S_DONE;
                end else if (i_stat.is_alloc) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_SCAN_RD;
                end else if (i_stat.loc_status != ST_OK) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = i_stat.loc_status;
                    o_cmd.res_kind   = KIND_ZERO;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rl_rd = 1'b1;
                    n_state = S_RL_CHK;
                end
            end
            S_RL_CHK: begin
                priority if (i_stat.rl_zero) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_NOT_ALLOC;
                    o_cmd.res_kind   = KIND_IDX;
                    n_state = S_DONE;
                end else if (i_stat.is_free) begin
                    o_cmd.take_run = 1'b1;
                    n_state = S_MOD_RD;
                end else begin
                    o_cmd.take_run   = 1'b1;
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_kind   = KIND_RUN;
                    n_state = S_DONE;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                priority if (i_stat.scan_found) begin
                    n_state = S_MOD_RD;
                end else if (i_stat.scan_end) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_EXHAUSTED;
                    o_cmd.res_kind   = KIND_ZERO;
                    n_state = S_DONE;
                end else if (i_stat.scan_wrap) begin
                    n_state = S_SCAN_RD;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_MOD_RD: begin
                o_cmd.mod_rd = 1'b1;
                n_state = S_MOD_WR;
            end
            S_MOD_WR: begin
                o_cmd.mod_wr = 1'b1;
                if (i_stat.mod_last) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_kind   = KIND_RUN;
                    n_state = S_DONE;
                end else begin
                    n_state = S_MOD_RD;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // a register write restarts the clearing pass
        if (i_stat.cfg_wr) begin
            o_cmd           = '0;
            o_cmd.clr_start = 1'b1;
            o_in_ready      = 1'b0;
            n_state         = S_CLEAR;
        end
    end

endmodule

// File: rtl/bffa_dp.sv
// Datapath of the allocator: config registers, free-map and run-length memories,
// chunked first-fit scan, run update and output register. Depends on bffa_pkg.
module bffa_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bffa_pkg::t_dp_cmd              i_cmd,
    output bffa_pkg::t_dp_stat             o_stat,
    input  logic                           i_cfg_valid,
    input  logic [bffa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic [1:0]                     i_cmd_in,
    input  logic [31:0]                    i_req_bytes,
    input  logic [31:0]                    i_address,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_status,
    output logic [31:0]                    o_result_address,
    output logic [bffa_pkg::BLK_W-1:0]     o_first_block,
    output logic [bffa_pkg::CNT_W-1:0]     o_run_blocks
);
    import bffa_pkg::*;

    // configuration
    logic [31:0]      r_pool_base;
    logic [CNT_W-1:0] r_pool_blocks;
    logic             cfg_hit;

    // latched transaction
    logic [1:0]  r_cmd;
    logic [31:0] r_req;
    logic [31:0] r_addr;

    // memories
    logic [WORD_W-1:0] r_fm [WORDS];
    logic [CNT_W-1:0]  r_rl [NUM_BLOCKS];
    logic [WORD_W-1:0] r_word;
    logic [CNT_W-1:0]  r_rl_q;
    logic [BLK_W-1:0]  r_clr_cnt;

    // scan and update state
    logic [CNT_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_n;
    logic [BLK_W-1:0]   r_s;
    logic [BLK_W-1:0]   r_e;
    logic [CNT_W-1:0]   r_run;
    logic [WADDR_W-1:0] r_w;

    // pending result
    t_status          r_res_status;
    logic [BLK_W-1:0] r_res_first;
    logic [CNT_W-1:0] r_res_run;
    logic             r_res_addr_en;

    logic             r_out_valid;

    // derived values
    logic [CNT_W-1:0]       total;
    logic [26:0]            need;
    logic [31:0]            off;
    logic [CNT_W+OFF_W-1:0] span;
    logic [BLK_W-1:0]       idx;
    t_status                loc_status;

    assign cfg_hit = i_cfg_valid &&
                     (i_cfg_index == REG_POOL_BASE || i_cfg_index == REG_POOL_BLOCKS);

    // clamp pool size, round request, check address
    always_comb begin
        total = (r_pool_blocks > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : r_pool_blocks;
        need  = r_req[31:OFF_W] + 27'(|r_req[OFF_W-1:0]);
        off   = r_addr - r_pool_base;
        span  = {total, {OFF_W{1'b0}}};
        idx   = off[OFF_W +: BLK_W];
        priority if (r_addr == 32'd0) begin
            loc_status = ST_NULL;
        end else if (r_addr < r_pool_base || off >= 32'(span)) begin
            loc_status = ST_RANGE;
        end else if (off[OFF_W-1:0] != '0) begin
            loc_status = ST_MISALIGNED;
        end else begin
            loc_status = ST_OK;
        end
    end

    // one chunk of the first-fit scan
    logic [CNT_W-1:0] sc_cnt;
    logic [CNT_W-1:0] sc_g;
    logic [CNT_W-1:0] sc_next;
    logic [BLK_W-1:0] sc_fpos;
    logic [BLK_W-1:0] sc_start;
    logic             sc_found;
    logic             sc_stop;
    always_comb begin
        sc_cnt   = r_cnt;
        sc_found = 1'b0;
        sc_stop  = 1'b0;
        sc_fpos  = '0;
        sc_g     = r_pos;
        for (int k = 0; k < CHUNK; k++) begin
            sc_g = r_pos + CNT_W'(k);
            if (!sc_found && !sc_stop) begin
                if (sc_g >= total) begin
                    sc_stop = 1'b1;
                end else begin
                    sc_cnt = r_word[{r_pos[BIT_W-1:CHUNK_W], CHUNK_W'(k)}] ?
                             sc_cnt + CNT_W'(1) : '0;
                    if (sc_cnt == r_n) begin
                        sc_found = 1'b1;
                        sc_fpos  = sc_g[BLK_W-1:0];
                    end
                end
            end
        end
        sc_next  = r_pos + CNT_W'(CHUNK);
        sc_start = sc_fpos - r_n[BLK_W-1:0] + BLK_W'(1);
    end

    // run update mask and end of a freed run
    logic [WORD_W-1:0] mask;
    logic [BLK_W-1:0]  g_blk;
    logic [BLK_W+1:0]  run_end;
    always_comb begin
        g_blk = '0;
        for (int b = 0; b < WORD_W; b++) begin
            g_blk   = {r_w, BIT_W'(b)};
            mask[b] = (g_blk >= r_s) && (g_blk <= r_e);
        end
        run_end = {2'b00, idx} + {1'b0, r_rl_q} - (BLK_W+2)'(1);
    end

    // status toward the controller
    always_comb begin
        o_stat            = '0;
        o_stat.cfg_wr     = cfg_hit;
        o_stat.clr_last   = &r_clr_cnt;
        o_stat.uninit     = (total == '0) || (r_pool_base == 32'd0);
        o_stat.is_alloc   = (r_cmd == CMD_ALLOC);
        o_stat.is_free    = (r_cmd == CMD_FREE);
        o_stat.req_zero   = (r_req == 32'd0);
        o_stat.req_exh    = need > 27'(total);
        o_stat.loc_status = loc_status;
        o_stat.rl_zero    = (r_rl_q == '0);
        o_stat.scan_found = sc_found;
        o_stat.scan_end   = sc_stop || (sc_next >= total);
        o_stat.scan_wrap  = (sc_next[BIT_W-1:0] == '0);
        o_stat.mod_last   = (r_w == r_e[BLK_W-1:BIT_W]);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= '0;
            r_pool_blocks <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_POOL_BASE) begin
                r_pool_base <= i_cfg_data;
            end else if (i_cfg_index == REG_POOL_BLOCKS) begin
                r_pool_blocks <= i_cfg_data[CNT_W-1:0];
            end
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_start) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= r_clr_cnt + BLK_W'(1);
        end
    end

    // free map memory: clear, read for scan or update, write back
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_fm[r_clr_cnt[WADDR_W-1:0]] <= '1;
        end else if (i_cmd.mod_wr) begin
            r_fm[r_w] <= (r_cmd == CMD_FREE) ? (r_word | mask) : (r_word & ~mask);
        end
        if (i_cmd.scan_rd) begin
            r_word <= r_fm[r_pos[BLK_W-1:BIT_W]];
        end else if (i_cmd.mod_rd) begin
            r_word <= r_fm[r_w];
        end
    end

    // run-length memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_rl[r_clr_cnt] <= '0;
        end else if (i_cmd.scan_step && sc_found) begin
            r_rl[sc_start] <= r_n;
        end else if (i_cmd.take_run && r_cmd == CMD_FREE) begin
            r_rl[idx] <= '0;
        end
        if (i_cmd.rl_rd) begin
            r_rl_q <= r_rl[idx];
        end
    end

    // transaction, scan and update registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd  <= i_cmd_in;
            r_req  <= i_req_bytes;
            r_addr <= i_address;
        end
        if (i_cmd.scan_init) begin
            r_pos <= '0;
            r_cnt <= '0;
            r_n   <= need[CNT_W-1:0];
        end else if (i_cmd.scan_step) begin
            r_pos <= sc_next;
            r_cnt <= sc_cnt;
            if (sc_found) begin
                r_s   <= sc_start;
                r_e   <= sc_fpos;
                r_run <= r_n;
                r_w   <= sc_start[BLK_W-1:BIT_W];
            end
        end
        if (i_cmd.take_run) begin
            r_s   <= idx;
            r_run <= r_rl_q;
            r_e   <= (run_end > (BLK_W+2)'(NUM_BLOCKS - 1)) ?
                     BLK_W'(NUM_BLOCKS - 1) : run_end[BLK_W-1:0];
            r_w   <= idx[BLK_W-1:BIT_W];
        end else if (i_cmd.mod_wr) begin
            r_w <= r_w + WADDR_W'(1);
        end
        if (i_cmd.set_res) begin
            r_res_status  <= i_cmd.res_status;
            r_res_first   <= '0;
            r_res_run     <= '0;
            r_res_addr_en <= 1'b0;
            unique case (i_cmd.res_kind)
                KIND_IDX: begin
                    r_res_first <= idx;
                end
                KIND_RUN: begin
                    r_res_first   <= (r_cmd == CMD_ALLOC) ? r_s : idx;
                    r_res_run     <= (r_cmd == CMD_ALLOC) ? r_run :
                                     (i_cmd.take_run ? r_rl_q : r_run);
                    r_res_addr_en <= (r_cmd == CMD_ALLOC);
                end
                default: begin
                    r_res_first <= '0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status         <= r_res_status;
            o_result_address <= r_res_addr_en ?
                                r_pool_base + {{(32-BLK_W-OFF_W){1'b0}}, r_res_first,
                                               {OFF_W{1'b0}}} : 32'd0;
            o_first_block    <= r_res_first;
            o_run_blocks     <= r_res_run;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/bitmap_first_fit_block_allocator_core.sv
// Allocation scans the free map first-fit, 8 blocks per cycle in the scan state
// with one map read per 32-block word, then marks the run word by word. A query
// returns the recorded run; a free also sets the run free word by word. One
// transaction at a time. Reset and every register write start a clearing pass through
// the free-map and run-length memories, during which no transaction is accepted.
// Holds the controller and datapath; depends on bffa_pkg, bffa_ctrl, bffa_dp.
module bitmap_first_fit_block_allocator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bffa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_cmd,
    input  logic [31:0]                    i_req_bytes,
    input  logic [31:0]                    i_address,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_status,
    output logic [31:0]                    o_result_address,
    output logic [bffa_pkg::BLK_W-1:0]     o_first_block,
    output logic [bffa_pkg::CNT_W-1:0]     o_run_blocks
);
    import bffa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    bffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bffa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd_in         (i_cmd),
        .i_req_bytes      (i_req_bytes),
        .i_address        (i_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_result_address (o_result_address),
        .o_first_block    (o_first_block),
        .o_run_blocks     (o_run_blocks)
    );

endmodule
